// ----- design/wmma_pkg.sv -----
// Shared constants for the sliding-window minimum, maximum and average block.
package wmma_pkg;

	// Window ring geometry.
	localparam int DEPTH = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SCAN_W = ADDR_W + 1;

	// Sample and statistic widths.
	localparam int SAMPLE_W = 32;
	localparam int STAT_W = SAMPLE_W - 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = STAT_W + ADDR_W;

	// Iterative divider: quotient bits produced per cycle and cycle count.
	localparam int QUOT_W = 32;
	localparam int HEAD_W = SUM_W - QUOT_W;
	localparam int DIV_STEPS = 4;
	localparam int DIV_ITERS = QUOT_W / DIV_STEPS;
	localparam int ITER_W = $clog2(DIV_ITERS);

endpackage

// ----- design/wmma_div.sv -----
// Iterative restoring divider that turns the window sum and count into the average.
module wmma_div import wmma_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               busy,
	output logic [QUOT_W-1:0]  quotient
);

	logic               busy_q;
	logic [ITER_W-1:0]  iter_q;
	logic [COUNT_W-1:0] divisor_q;
	logic [COUNT_W-1:0] rem_q;
	logic [QUOT_W-1:0]  num_q;
	logic [COUNT_W-1:0] rem_next;
	logic [QUOT_W-1:0]  num_next;

	// Several quotient bits per cycle; the remainder stays below the divisor,
	// so each partial remainder fits in one bit more than the count.
	always_comb begin
		logic [COUNT_W:0] part;
		rem_next = rem_q;
		num_next = num_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			part = {rem_next, num_next[QUOT_W-1]};
			if (part >= {1'b0, divisor_q}) begin
				rem_next = COUNT_W'(part - {1'b0, divisor_q});
				num_next = {num_next[QUOT_W-2:0], 1'b1};
			end else begin
				rem_next = part[COUNT_W-1:0];
				num_next = {num_next[QUOT_W-2:0], 1'b0};
			end
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == ITER_W'(DIV_ITERS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand and partial result registers. The top bits of the sum are
	// always below the count, so they seed the remainder directly.
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= COUNT_W'(dividend[SUM_W-1:QUOT_W]);
			num_q     <= dividend[QUOT_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= num_next;
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule

// ----- design/window_min_max_average_core.sv -----
// Sliding window of timing samples with count, minimum, maximum and average.
//
// Usage: each request on the sample channel (sample_valid high, sample_stall
// low) writes one signed Q16.16 sample into a 64-entry ring, replacing the
// oldest entry. The block then reads the whole ring from its memory, one
// entry per cycle, and keeps count, sum, minimum and maximum of the strictly
// positive entries. An iterative divider producing four quotient bits per
// cycle forms the truncated average. One result request follows on the
// result channel (result_valid, result_stall).
// The memory scan uses the one read port; the divider is skipped when no
// entry is positive. sample_stall is high while a sample is being processed,
// from acceptance until its result is loaded into the output register, so
// the block takes no new sample before it is through with the last one.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; if the receiver still stalls when the next result
// is ready, the block holds it and keeps sample_stall high.
// Reset: all ring entries read as zero (per-entry valid flags are cleared),
// the write slot returns to entry zero and no result is pending.
module window_min_max_average_core import wmma_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [STAT_W-1:0]  average,
	output logic [STAT_W-1:0]  minimum,
	output logic [STAT_W-1:0]  maximum,
	output logic [COUNT_W-1:0] positive_count
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIVS = 3'd2;
	localparam logic [2:0] ST_DIVW = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   wr_ptr_q;
	logic [DEPTH-1:0]    vld_q;
	logic [SCAN_W-1:0]   rd_addr_q;
	logic                rd_en_s1;
	logic                ent_vld_s1;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic [SAMPLE_W-1:0] window_mem [DEPTH];

	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [STAT_W-1:0]   lo_q;
	logic [STAT_W-1:0]   hi_q;

	logic                out_vld_q;
	logic [STAT_W-1:0]   avg_q;
	logic [STAT_W-1:0]   min_q;
	logic [STAT_W-1:0]   max_q;
	logic [COUNT_W-1:0]  cnt_q;

	logic                accept;
	logic                scan_issue;
	logic                scan_last;
	logic                div_start;
	logic                div_busy;
	logic [QUOT_W-1:0]   div_quot;
	logic                load_out;
	logic [SAMPLE_W-1:0] entry;
	logic                entry_pos;

	assign accept     = sample_valid && (state_q == ST_IDLE);
	assign scan_issue = (state_q == ST_SCAN) && (rd_addr_q != SCAN_W'(DEPTH));
	assign scan_last  = (state_q == ST_SCAN) && (rd_addr_q == SCAN_W'(DEPTH));
	assign div_start  = (state_q == ST_DIVS) && (count_q != '0);
	assign load_out   = (state_q == ST_FIN) && (!out_vld_q || !result_stall);

	// Window memory: one write port for new samples, one registered read port.
	always_ff @(posedge clk) begin
		if (accept) begin
			window_mem[wr_ptr_q] <= sample;
		end
		rd_data_s1 <= window_mem[rd_addr_q[ADDR_W-1:0]];
	end

	// Entry valid flags stand in for clearing the memory at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			wr_ptr_q   <= '0;
			ent_vld_s1 <= 1'b0;
			rd_en_s1   <= 1'b0;
		end else begin
			if (accept) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q        <= wr_ptr_q + 1'b1;
			end
			ent_vld_s1 <= vld_q[rd_addr_q[ADDR_W-1:0]];
			rd_en_s1   <= scan_issue;
		end
	end

	assign entry     = ent_vld_s1 ? rd_data_s1 : '0;
	assign entry_pos = (entry != '0) && !entry[SAMPLE_W-1];

	// Sequencer for write, scan, divide and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_SCAN;
						rd_addr_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DIVS;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_DIVS: begin
					state_q <= (count_q != '0) ? ST_DIVW : ST_FIN;
				end
				ST_DIVW: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running statistics over the positive entries of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= '0;
			sum_q   <= '0;
			lo_q    <= '1;
			hi_q    <= '0;
		end else if (rd_en_s1 && entry_pos) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + SUM_W'(entry[STAT_W-1:0]);
			if (entry[STAT_W-1:0] < lo_q) begin
				lo_q <= entry[STAT_W-1:0];
			end
			if (entry[STAT_W-1:0] > hi_q) begin
				hi_q <= entry[STAT_W-1:0];
			end
		end
	end

	wmma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output payload; an empty window reports all zeros.
	always_ff @(posedge clk) begin
		if (load_out) begin
			cnt_q <= count_q;
			avg_q <= (count_q != '0) ? div_quot[STAT_W-1:0] : '0;
			min_q <= (count_q != '0) ? lo_q : '0;
			max_q <= hi_q;
		end
	end

	assign sample_stall   = (state_q != ST_IDLE);
	assign result_valid   = out_vld_q;
	assign average        = avg_q;
	assign minimum        = min_q;
	assign maximum        = max_q;
	assign positive_count = cnt_q;

`ifndef ASSERT_OFF
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> state_q == ST_SCAN)
		else $error("accepted sample did not start a scan");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVW |-> count_q != '0)
		else $error("divider running with a zero count");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> minimum <= maximum)
		else $error("result minimum above maximum");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> positive_count <= COUNT_W'(DEPTH))
		else $error("positive count beyond window depth");

	a_avg_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && positive_count != '0 |-> average >= minimum && average <= maximum)
		else $error("average outside minimum and maximum");
`endif

endmodule

// ----- sim/window_stats_monitor.sv -----
// Checker that predicts and compares the window statistics of the block.
module window_stats_monitor import wmma_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic [STAT_W-1:0]   average,
	input  logic [STAT_W-1:0]   minimum,
	input  logic [STAT_W-1:0]   maximum,
	input  logic [COUNT_W-1:0]  positive_count,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STAT_W-1:0]  average;
		logic [STAT_W-1:0]  minimum;
		logic [STAT_W-1:0]  maximum;
		logic [COUNT_W-1:0] count;
	} window_stats_t;

	// Private copy of the sample ring and of its write slot.
	logic [SAMPLE_W-1:0] window_copy [DEPTH];
	logic [ADDR_W-1:0]   next_slot;
	window_stats_t       expected_stats [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// Scan the ring and summarize its strictly positive entries.
	function automatic window_stats_t scan_window();
		window_stats_t       stats;
		logic [63:0]         total;
		int unsigned         n;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] entry;
		total = '0;
		n = 0;
		lo = '1;
		hi = '0;
		for (int i = 0; i < DEPTH; i++) begin
			entry = window_copy[i];
			if (entry != '0 && !entry[SAMPLE_W-1]) begin
				n++;
				total += entry;
				if (entry < lo) lo = entry;
				if (entry > hi) hi = entry;
			end
		end
		if (n != 0) begin
			stats.average = STAT_W'(total / n);
			stats.minimum = STAT_W'(lo);
			stats.maximum = STAT_W'(hi);
		end else begin
			stats.average = '0;
			stats.minimum = '0;
			stats.maximum = '0;
		end
		stats.count = COUNT_W'(n);
		return stats;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Results are matched before the new request is predicted, since a result
	// can never leave in the same cycle as the sample that caused it.
	always @(posedge clk or negedge arst_n) begin
		window_stats_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) window_copy[i] = '0;
			next_slot = '0;
			expected_stats.delete();
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_stats.size() == 0) begin
					$display("%0t ns: result request with none expected, average %0d", $time,
						average);
					mismatches++;
				end else begin
					want = expected_stats.pop_front();
					check_field("average", want.average, average);
					check_field("minimum", want.minimum, minimum);
					check_field("maximum", want.maximum, maximum);
					check_field("positive_count", want.count, positive_count);
				end
			end
			if (sample_valid && !sample_stall) begin
				window_copy[next_slot] = sample;
				next_slot = next_slot + 1'b1;
				expected_stats.push_back(scan_window());
			end
			outstanding = expected_stats.size();
		end
	end

endmodule

// ----- sim/window_min_max_average_core_tb.sv -----
// Testbench top for the sliding-window minimum, maximum and average block.
module window_min_max_average_core_tb import wmma_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS = 283;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 150;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample;
	logic                result_valid;
	logic                result_stall;
	logic [STAT_W-1:0]   average;
	logic [STAT_W-1:0]   minimum;
	logic [STAT_W-1:0]   maximum;
	logic [COUNT_W-1:0]  positive_count;
	int                  mismatches;
	int                  outstanding;

	// Idling rates of the current phase and the one long receiver hold-off.
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_wanted = 1'b0;
	int quiet_cycles = 0;

	window_min_max_average_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.average(average),
		.minimum(minimum),
		.maximum(maximum),
		.positive_count(positive_count)
	);

	window_stats_monitor stats_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.average(average),
		.minimum(minimum),
		.maximum(maximum),
		.positive_count(positive_count),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random sample, positive with at least the given chance in percent.
	function automatic logic [SAMPLE_W-1:0] pick_sample(input int positive_pct);
		logic [SAMPLE_W-1:0] v;
		v = $urandom;
		if ($urandom_range(0, 99) < positive_pct) begin
			case ($urandom_range(0, 2))
				0: v[SAMPLE_W-1] = 1'b0;
				1: v = {1'b0, {(SAMPLE_W-17){1'b1}}, v[15:0]};
				default: v = $urandom_range(1, 32'h0003_0000);
			endcase
			if (v == '0) v = 1;
		end else begin
			case ($urandom_range(0, 3))
				0: v = '0;
				1: v[SAMPLE_W-1] = 1'b1;
				2: v = $urandom_range(0, 1) ? {1'b1, {(SAMPLE_W-1){1'b0}}} : '1;
				default: ;
			endcase
		end
		return v;
	endfunction

	// Offer one sample request and hold it until the block takes it.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			sample <= $urandom;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (sample_stall);
	endtask

	// Hold the sender back until every expected result has come out.
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	// Receiver stalls, with one long hold-off once it is asked for.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles + 1 >= QUIET_LIMIT) begin
					$display("%0t ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [SAMPLE_W-1:0] directed [$];
		int                  idle_by_phase [4];
		int                  stall_by_phase [4];
		int                  bias_levels [6];
		int                  positive_pct;
		directed = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
			32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'h5555_5555,
			32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_0000, 32'h0000_8000,
			32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0003, 32'h3FFF_FFFF, 32'hC000_0000,
			32'h0000_FFFF};
		idle_by_phase = '{0, 82, 0, 17};
		stall_by_phase = '{0, 0, 82, 17};
		bias_levels = '{100, 100, 90, 60, 20, 0};
		positive_pct = 90;

		sample_valid = 1'b0;
		sample = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed samples: empty window, sign extremes, largest and smallest
		// positive values, zero and negative entries mixed with positive ones.
		idle_pct = 17;
		stall_pct = 17;
		foreach (directed[i]) offer_sample(directed[i]);
		drain_results();

		// Random samples over the idling phases; the bias changes every few
		// dozen samples so that whole windows of positives also occur.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 48 == 0) positive_pct = bias_levels[$urandom_range(0, 5)];
				if (ph == 0 && n == 20) hold_wanted = 1'b1;
				if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
				offer_sample(pick_sample(positive_pct));
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (outstanding != 0) $display("%0t ns: %0d results never arrived", $time,
				outstanding);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
